// ----- sv/bgm_pkg.sv -----
// ----------------------------------------------------------------------------
// bgm_pkg
// Shared types, sizes and helper functions of the binary Gram-matrix engine.
// ----------------------------------------------------------------------------
package bgm_pkg;

	// store and row sizes
	localparam int MAX_POINTS = 64;
	localparam int MAX_BLOCKS = 64;

	// field widths fixed by the interface
	localparam int ROW_W = 64;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;
	localparam int NB_W  = 7;

	// store addressing and fill counter
	localparam int ADDR_W = $clog2(MAX_POINTS);
	localparam int SEEN_W = $clog2(MAX_POINTS + 1);

	localparam logic [NB_W-1:0]   NB_RESET = NB_W'(MAX_BLOCKS);
	localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(MAX_POINTS);

	// one input request
	typedef struct packed {
		logic [ROW_W-1:0] row_bits;
		logic             last_row;
	} item_t;

	// one result
	typedef struct packed {
		logic [IDX_W-1:0] row_index;
		logic [IDX_W-1:0] col_index;
		logic [CNT_W-1:0] common_count;
		logic             last_of_run;
		logic             overflow;
	} res_t;

	// controller to datapath commands
	typedef struct packed {
		logic              load;
		logic [ADDR_W-1:0] wr_addr;
		logic              rd;
		logic              ovf;
		logic [IDX_W-1:0]  row_idx;
		logic [IDX_W-1:0]  col_idx;
		logic              last;
	} cmd_t;

	// mask of the blocks in use, count clamped to MAX_BLOCKS
	function automatic logic [ROW_W-1:0] block_mask(input logic [NB_W-1:0] nb);
		logic [NB_W-1:0]  lim;
		logic [ROW_W-1:0] m;
		lim = (nb > NB_W'(MAX_BLOCKS)) ? NB_W'(MAX_BLOCKS) : nb;
		for (int h = 0; h < ROW_W; h++) begin
			m[h] = (NB_W'(h) < lim);
		end
		return m;
	endfunction

	// adder-tree population count of one row
	function automatic logic [CNT_W-1:0] popcount(input logic [ROW_W-1:0] x);
		logic [CNT_W-1:0] s [ROW_W];
		for (int i = 0; i < ROW_W; i++) begin
			s[i] = CNT_W'(x[i]);
		end
		for (int lvl = 0; lvl < $clog2(ROW_W); lvl++) begin
			for (int i = 0; i < (ROW_W >> (lvl + 1)); i++) begin
				s[i] = s[2*i] + s[2*i+1];
			end
		end
		return s[0];
	endfunction

endpackage

// ----- sv/bgm_ram.sv -----
// ----------------------------------------------------------------------------
// bgm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bgm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/bgm_ctrl.sv -----
// ----------------------------------------------------------------------------
// bgm_ctrl
// Controller: tracks the fill of the row store and sequences the reads of
// one run, one stored row per cycle.
// ----------------------------------------------------------------------------
module bgm_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         last_row,
	output logic         busy,
	output bgm_pkg::cmd_t cmd
);
	import bgm_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic              state_q;
	logic [SEEN_W-1:0] seen_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] col_q;
	logic              accept;
	logic              full;
	logic              run_end;

	assign busy    = (state_q == ST_RUN);
	assign accept  = start && !busy;
	assign full    = (seen_q >= SEEN_FULL);
	assign run_end = (col_q == idx_q);

	// commands to the datapath
	always_comb begin
		cmd.load    = accept && !full;
		cmd.wr_addr = seen_q[ADDR_W-1:0];
		cmd.rd      = busy;
		cmd.ovf     = accept && full;
		cmd.row_idx = IDX_W'(idx_q);
		cmd.col_idx = IDX_W'(col_q);
		cmd.last    = run_end;
	end

	// state, fill count and run counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q  <= '0;
			idx_q   <= '0;
			col_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!full) begin
							idx_q   <= seen_q[ADDR_W-1:0];
							col_q   <= '0;
							state_q <= ST_RUN;
							seen_q  <= last_row ? '0 : seen_q + 1'b1;
						end else if (last_row) begin
							seen_q <= '0;
						end
					end
				end
				ST_RUN: begin
					if (run_end) begin
						state_q <= ST_IDLE;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/bgm_dp.sv -----
// ----------------------------------------------------------------------------
// bgm_dp
// Datapath: block-count register, row masking, row store, and the
// AND-popcount pipeline that forms each result.
// ----------------------------------------------------------------------------
module bgm_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bgm_pkg::cmd_t                cmd,
	input  logic [bgm_pkg::ROW_W-1:0]    row_bits,
	input  logic                         cfg_valid,
	input  logic [bgm_pkg::NB_W-1:0]     cfg_data,
	output bgm_pkg::res_t                result,
	output logic                         strobe
);
	import bgm_pkg::*;

	logic [NB_W-1:0]  num_blocks_q;
	logic [ROW_W-1:0] row_masked;
	logic [ROW_W-1:0] row_q;
	logic [ROW_W-1:0] rd_data;

	logic             valid_s1;
	logic             ovf_s1;
	logic             last_s1;
	logic [IDX_W-1:0] row_idx_s1;
	logic [IDX_W-1:0] col_idx_s1;
	logic [ROW_W-1:0] row_s1;

	res_t             res_q;
	logic             strobe_q;

	// block count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_blocks_q <= NB_RESET;
		end else if (cfg_valid) begin
			num_blocks_q <= cfg_data;
		end
	end

	assign row_masked = row_bits & block_mask(num_blocks_q);

	// new row held for the whole run
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_q <= row_masked;
		end
	end

	// row store
	bgm_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (cmd.wr_addr),
		.wdata (row_masked),
		.re    (cmd.rd),
		.raddr (cmd.col_idx[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	// stage 1 control, aligned with the store read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd || cmd.ovf;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (cmd.rd || cmd.ovf) begin
			ovf_s1     <= cmd.ovf;
			last_s1    <= cmd.ovf || cmd.last;
			row_idx_s1 <= cmd.ovf ? '0 : cmd.row_idx;
			col_idx_s1 <= cmd.ovf ? '0 : cmd.col_idx;
			row_s1     <= row_q;
		end
	end

	// output register strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= valid_s1;
		end
	end

	// output register payload: AND and count of common blocks
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_q.row_index    <= row_idx_s1;
			res_q.col_index    <= col_idx_s1;
			res_q.common_count <= ovf_s1 ? '0 : popcount(row_s1 & rd_data);
			res_q.last_of_run  <= last_s1;
			res_q.overflow     <= ovf_s1;
		end
	end

	assign result = res_q;
	assign strobe = strobe_q;

endmodule

// ----- sv/binary_gram_matrix_engine.sv -----
// ----------------------------------------------------------------------------
// binary_gram_matrix_engine
// Lower triangle of A * A^T for a 0/1 incidence matrix, one point row in,
// one result per stored row out.
// ----------------------------------------------------------------------------
// usage
//   request channel: item is taken at a clock edge with start high and busy
//   low. The row is masked to num_blocks columns and written to the store unless the store is full.
//   result channel: strobe marks one result for one cycle; there is no
//   back-pressure, the receiver must take every result as it comes.
//   config channel: cfg_valid with cfg_data writes num_blocks; cfg_ready is
//   always high. Write only while no run is in flight.
// timing
//   row n of a matrix (n from 0) gives n+1 results, one per cycle, the first
//   after the store read with stage 1 and then the output register. busy stays
//   high while the run reads the stored rows through the single read port
//   of the row store, so a new request waits until busy is low again.
//   A row with the store full gives one overflow result through the stage-1
//   and output registers and leaves busy low.
// reset
//   arst_n clears the fill count and sets num_blocks to 64; the store itself
//   is not cleared, only rows of the current matrix are read.
// ----------------------------------------------------------------------------
module binary_gram_matrix_engine (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  bgm_pkg::item_t           item,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [bgm_pkg::NB_W-1:0] cfg_data,
	output bgm_pkg::res_t            result,
	output logic                     strobe
);
	import bgm_pkg::*;

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	// sequencer
	bgm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.last_row (item.last_row),
		.busy     (busy),
		.cmd      (cmd)
	);

	// store and count pipeline
	bgm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.row_bits  (item.row_bits),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.result    (result),
		.strobe    (strobe)
	);

endmodule

// ----- sv/bgm_chk.sv -----
// ----------------------------------------------------------------------------
// bgm_chk
// Port-level checks of the result stream of the Gram-matrix engine.
// ----------------------------------------------------------------------------
module bgm_chk (
	input  logic          clk,
	input  logic          arst_n,
	input  bgm_pkg::res_t result,
	input  logic          strobe
);
	import bgm_pkg::*;

	// overflow result ends its run and carries zero fields
	a_ovf_fields: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.overflow |-> result.last_of_run && result.row_index == '0 &&
			result.col_index == '0 && result.common_count == '0)
		else $error("overflow result with nonzero fields");

	// pairs stay in the lower triangle, diagonal ends the run
	a_triangle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.overflow |-> result.col_index <= result.row_index &&
			result.last_of_run == (result.col_index == result.row_index))
		else $error("result outside lower triangle");

	// count never exceeds the block limit
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> result.common_count <= CNT_W'(MAX_BLOCKS))
		else $error("common count above block limit");

	// a run streams without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_of_run |=> strobe)
		else $error("gap inside a run");

	// consecutive results of one run step the column by one
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_of_run |=>
			result.col_index == $past(result.col_index) + 1'b1 &&
			result.row_index == $past(result.row_index))
		else $error("column index did not advance");

endmodule

bind binary_gram_matrix_engine bgm_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.result (result),
	.strobe (strobe)
);
